// ===== hw/rtl/ssi_pkg.sv =====
// Shared constants for the segment/sphere intersection pipeline.
// No dependencies; used by ssi_wmul and segment_sphere_intersection.
package ssi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int MUL_CHUNK       = 32;

endpackage

// ===== hw/rtl/segment_sphere_intersection.sv =====
// Segment against sphere intersection, one request per cycle while out_stall does not hold the pipeline.
// The root search takes one stage per result bit; two multiplier banks lie ahead of it.
// The whole pipeline holds while a finished result waits under out_stall.
// Synchronous active-low reset clears all valid bits; no clearing pass.
// Depends on ssi_pkg and ssi_wmul.
module segment_sphere_intersection #(
  parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = ssi_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic        [COORD_WIDTH-2:0] in_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic        [T_FRAC_BITS:0]   out_t_hit
);

  localparam int W   = COORD_WIDTH;
  localparam int T   = T_FRAC_BITS;
  localparam int AW  = 2*W;
  localparam int HW  = 2*W + 2;
  localparam int CWD = 2*W + 3;
  localparam int FW  = 2*W + 5;
  localparam int MHW = 2*W + 1;
  localparam int CPW = 2*W + 2;
  localparam int PW  = 4*W + 2;
  localparam int GW  = 2*W + T + 3;
  localparam int QW  = 2*W + 2*T + 5;
  localparam int NS  = T + 1;

  logic en;

  // stage 1
  logic signed [W:0]   d1_r [3];
  logic signed [W-1:0] u1_r [3];
  logic [W-2:0]        r1_r;
  logic                v1_r;
  logic signed [W-1:0] st_in [3];
  logic signed [W-1:0] ce_in [3];
  logic signed [W-1:0] di_in [3];

  // stage 2
  logic [W-1:0] um2_r [3];
  logic [W:0]   dm2_r [3];
  logic         hn2_r [3];
  logic [W-2:0] r2_r;
  logic         v2_r;

  // product bank one
  logic [2*W-1:0] uu_p [3];
  logic [2*W:0]   ud_p [3];
  logic [2*W+1:0] dd_p [3];
  logic [2*W-3:0] rr_p;
  logic           hn3_r [3];
  logic           hn4_r [3];
  logic           v3_r, v4_r;

  // stage 5
  logic [AW-1:0]         a5_r;
  logic signed [HW-1:0]  h5_r;
  logic signed [CWD-1:0] c5_r;
  logic                  v5_r;
  logic [AW-1:0]         a_sum;
  logic signed [HW-1:0]  h_sum;
  logic signed [CWD-1:0] c_sum;

  // stage 6
  logic signed [FW-1:0]  f1;
  logic signed [FW-1:0]  vert;
  logic                  cneg, azero, czero, far6;
  logic signed [HW-1:0]  hneg_v;
  logic [AW-1:0]         a6_r, a7_r, a8_r;
  logic signed [HW-1:0]  h6_r, h7_r, h8_r;
  logic signed [CWD-1:0] c6_r, c7_r, c8_r;
  logic                  m6_r, m7_r, m8_r;
  logic                  s6_r, s7_r, s8_r;
  logic [MHW-1:0]        hm6_r;
  logic [CPW-1:0]        cp6_r;
  logic                  v6_r, v7_r, v8_r;
  logic [PW-1:0]         hh_p, ac_p;

  // root search, index 0 is the seed stage
  logic [T:0]           sk_r [NS+1];
  logic signed [GW-1:0] sg_r [NS+1];
  logic signed [QW-1:0] sq_r [NS+1];
  logic [AW-1:0]        sa_r [NS+1];
  logic                 sm_r [NS+1];
  logic                 ss_r [NS+1];
  logic                 sv_r [NS+1];
  logic signed [GW-1:0] cg [NS];
  logic signed [QW-1:0] cq [NS];
  logic                 tk [NS];

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [T:0]           out_t_hit_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign st_in[0] = in_start_x;
  assign st_in[1] = in_start_y;
  assign st_in[2] = in_start_z;
  assign ce_in[0] = in_center_x;
  assign ce_in[1] = in_center_y;
  assign ce_in[2] = in_center_z;
  assign di_in[0] = in_dir_x;
  assign di_in[1] = in_dir_y;
  assign di_in[2] = in_dir_z;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      for (int s = 0; s <= NS; s++) begin
        sv_r[s] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      sv_r[0]     <= v8_r;
      for (int s = 0; s < NS; s++) begin
        sv_r[s+1] <= sv_r[s];
      end
      out_valid_r <= sv_r[NS];
    end
  end

  // stages 1 and 2: offsets, magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= (W+1)'(st_in[i]) - (W+1)'(ce_in[i]);
        u1_r[i]  <= di_in[i];
        um2_r[i] <= u1_r[i][W-1] ? W'(~u1_r[i] + W'(1)) : W'(u1_r[i]);
        dm2_r[i] <= d1_r[i][W] ? (W+1)'(~d1_r[i] + (W+1)'(1)) : (W+1)'(d1_r[i]);
        hn2_r[i] <= u1_r[i][W-1] ^ d1_r[i][W];
        hn3_r[i] <= hn2_r[i];
        hn4_r[i] <= hn3_r[i];
      end
      r1_r <= in_radius;
      r2_r <= r1_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    ssi_wmul #(.WA(W), .WB(W)) u_uu (
      .clk(clk), .en(en), .a(um2_r[i]), .b(um2_r[i]), .p(uu_p[i])
    );
    ssi_wmul #(.WA(W), .WB(W+1)) u_ud (
      .clk(clk), .en(en), .a(um2_r[i]), .b(dm2_r[i]), .p(ud_p[i])
    );
    ssi_wmul #(.WA(W+1), .WB(W+1)) u_dd (
      .clk(clk), .en(en), .a(dm2_r[i]), .b(dm2_r[i]), .p(dd_p[i])
    );
  end

  ssi_wmul #(.WA(W-1), .WB(W-1)) u_rr (
    .clk(clk), .en(en), .a(r2_r), .b(r2_r), .p(rr_p)
  );

  // stage 5: quadratic coefficients
  always_comb begin
    a_sum = AW'(uu_p[0]) + AW'(uu_p[1]) + AW'(uu_p[2]);
    h_sum = '0;
    for (int i = 0; i < 3; i++) begin
      h_sum = hn4_r[i] ? h_sum - $signed(HW'(ud_p[i])) : h_sum + $signed(HW'(ud_p[i]));
    end
    c_sum = $signed(CWD'(dd_p[0])) + $signed(CWD'(dd_p[1])) + $signed(CWD'(dd_p[2]))
          - $signed(CWD'(rr_p));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a5_r <= a_sum;
      h5_r <= h_sum;
      c5_r <= c_sum;
    end
  end

  // stage 6: early decisions
  always_comb begin
    cneg   = c5_r < 0;
    azero  = a5_r == '0;
    czero  = c5_r == '0;
    f1     = $signed(FW'(a5_r)) + (FW'(h5_r) <<< 1) + FW'(c5_r);
    vert   = -FW'(h5_r) - $signed(FW'(a5_r));
    far6   = (f1 > 0) && (vert > 0);
    hneg_v = -h5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a6_r  <= a5_r;
      h6_r  <= h5_r;
      c6_r  <= c5_r;
      m6_r  <= cneg || azero || (!czero && ((h5_r >= 0) || far6));
      s6_r  <= !cneg && !azero && czero;
      hm6_r <= hneg_v[MHW-1:0];
      cp6_r <= c5_r[CPW-1:0];
      a7_r  <= a6_r;
      h7_r  <= h6_r;
      c7_r  <= c6_r;
      m7_r  <= m6_r;
      s7_r  <= s6_r;
      a8_r  <= a7_r;
      h8_r  <= h7_r;
      c8_r  <= c7_r;
      m8_r  <= m7_r;
      s8_r  <= s7_r;
    end
  end

  ssi_wmul #(.WA(MHW), .WB(MHW)) u_hh (
    .clk(clk), .en(en), .a(hm6_r), .b(hm6_r), .p(hh_p)
  );

  ssi_wmul #(.WA(AW), .WB(CPW)) u_ac (
    .clk(clk), .en(en), .a(a6_r), .b(cp6_r), .p(ac_p)
  );

  // root search: one result bit per stage, f and its slope advanced by shifts and adds
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      cg[s] = sg_r[s] + $signed(GW'(sa_r[s]) << (T - s));
      cq[s] = sq_r[s] + (QW'(sg_r[s]) <<< (T - s + 1))
            + $signed(QW'(sa_r[s]) << (2*(T - s)));
      tk[s] = !sk_r[s][T] && (cg[s] <= 0) && (cq[s] >= 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sk_r[0] <= '0;
      sg_r[0] <= GW'(h8_r) <<< T;
      sq_r[0] <= QW'(c8_r) <<< (2*T);
      sa_r[0] <= a8_r;
      sm_r[0] <= m8_r || (!s8_r && (hh_p < ac_p));
      ss_r[0] <= s8_r;
      for (int s = 0; s < NS; s++) begin
        sk_r[s+1] <= tk[s] ? (sk_r[s] | ((T+1)'(1) << (T - s))) : sk_r[s];
        sg_r[s+1] <= tk[s] ? cg[s] : sg_r[s];
        sq_r[s+1] <= tk[s] ? cq[s] : sq_r[s];
        sa_r[s+1] <= sa_r[s];
        sm_r[s+1] <= sm_r[s];
        ss_r[s+1] <= ss_r[s];
      end
      out_hit_r   <= !sm_r[NS];
      out_t_hit_r <= (sm_r[NS] || ss_r[NS]) ? '0 : sk_r[NS];
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_t_hit = out_t_hit_r;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_t_hit == '0)
    else $error("miss with nonzero t_hit");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_t_hit <= ((T+1)'(1) << T))
    else $error("t_hit above one");

  a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held without a waiting result");
`endif

endmodule

// ===== hw/rtl/ssi_wmul.sv =====
// Pipelined unsigned wide multiplier: chunked partial products, then summation.
// Partial products and the sum are each registered on enabled cycles. Depends on ssi_pkg.
module ssi_wmul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic [WA-1:0]      a,
  input  logic [WB-1:0]      b,
  output logic [WA+WB-1:0]   p
);

  localparam int CW = ssi_pkg::MUL_CHUNK;
  localparam int NA = (WA + CW - 1) / CW;
  localparam int NB = (WB + CW - 1) / CW;
  localparam int PW = (NA + NB) * CW;

  logic [NA*CW-1:0] a_ext;
  logic [NB*CW-1:0] b_ext;
  logic [2*CW-1:0]  pp_r [NA][NB];
  logic [PW-1:0]    acc;
  logic [WA+WB-1:0] p_r;

  assign a_ext = (NA*CW)'(a);
  assign b_ext = (NB*CW)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= (2*CW)'(a_ext[i*CW +: CW]) * (2*CW)'(b_ext[j*CW +: CW]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp_r[i][j]) << ((i + j) * CW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc[WA+WB-1:0];
    end
  end

  assign p = p_r;

endmodule

// ===== verif/ssi_checker.sv =====
// Checker for segment_sphere_intersection: watches both channels, predicts each result
// in exact wide integer arithmetic and compares it field by field with the block's output.
// Depends only on the ports of the block; no package functions are reused.
`timescale 1ns / 100ps

module ssi_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_start_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic        [30:0] in_radius,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic        [16:0] out_t_hit,
  output int                 fails,
  output int                 pending,
  output int                 hits_seen
);

  typedef logic signed [255:0] wint_t;
  typedef struct packed {
    logic        hit;
    logic [16:0] t;
  } crossing_t;

  localparam wint_t TSCALE = wint_t'(65536);

  crossing_t crossings_due[$];

  function automatic crossing_t first_crossing(
    wint_t sx, wint_t sy, wint_t sz, wint_t ux, wint_t uy, wint_t uz,
    wint_t cx, wint_t cy, wint_t cz, wint_t r);
    wint_t dx, dy, dz, a, h, c, delta, f1, hs, cs, cand, q;
    crossing_t res;
    int k;
    dx = sx - cx;
    dy = sy - cy;
    dz = sz - cz;
    a = ux * ux + uy * uy + uz * uz;
    h = ux * dx + uy * dy + uz * dz;
    c = dx * dx + dy * dy + dz * dz - r * r;
    res = '0;
    if (c < 0 || a == 0) return res;
    if (c == 0) begin
      res.hit = 1'b1;
      return res;
    end
    if (h >= 0) return res;
    delta = h * h - a * c;
    if (delta < 0) return res;
    f1 = a + h + h + c;
    if (f1 > 0 && (-h - a) > 0) return res;
    hs = h * TSCALE;
    cs = c * TSCALE * TSCALE;
    k = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = wint_t'(k | (1 << b));
      if (cand > TSCALE) continue;
      if (a * cand + hs > 0) continue;
      q = a * cand * cand + 2 * hs * cand + cs;
      if (q < 0) continue;
      k = int'(cand);
    end
    res.hit = 1'b1;
    res.t   = k[16:0];
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    hits_seen = 0;
  end

  always @(posedge clk) begin
    crossing_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        crossings_due = {crossings_due, first_crossing(in_start_x, in_start_y, in_start_z,
          in_dir_x, in_dir_y, in_dir_z, in_center_x, in_center_y, in_center_z,
          wint_t'(in_radius))};
      if (out_valid && !out_stall) begin
        if (crossings_due.size() == 0) begin
          report("unexpected result, hit", out_hit, 0);
        end else begin
          want = crossings_due.pop_front();
          if (out_hit !== want.hit) report("hit", out_hit, want.hit);
          if (out_t_hit !== want.t) report("t_hit", out_t_hit, want.t);
          if (want.hit) hits_seen++;
        end
      end
      pending <= crossings_due.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the segment_sphere_intersection testbench: clock, reset, request stimulus
// with random idling and back-pressure, and the verdict. Depends on segment_sphere_intersection and ssi_checker.
`timescale 1ns / 100ps

module testbench;

  localparam int ONE = 65536;
  localparam int RANDOM_REQUESTS = 1630;
  localparam int CYCLE_LIMIT = 2000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic        [30:0] in_radius = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic        [16:0] out_t_hit;

  int  fails, pending, hits_seen;
  int  requests_sent = 0;
  int  cycles = 0;
  bit  hold_off_due = 1'b0;
  bit  quiet_sender = 1'b0;
  bit  quiet_receiver = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  segment_sphere_intersection uut (.*);

  ssi_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(int sx, int sy, int sz, int ux, int uy, int uz,
                      int cx, int cy, int cz, int r);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(13, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_start_x  <= sx;
    in_start_y  <= sy;
    in_start_z  <= sz;
    in_dir_x    <= ux;
    in_dir_y    <= uy;
    in_dir_z    <= uz;
    in_center_x <= cx;
    in_center_y <= cy;
    in_center_z <= cz;
    in_radius   <= r[30:0];
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Well-formed request: segment aimed near the sphere at a random scale.
  task automatic send_aimed();
    int span, sx, sy, sz, cx, cy, cz, r, shift;
    span = 1 << $urandom_range(28, 6);
    cx = $urandom_range(2 * span, 0) - span;
    cy = $urandom_range(2 * span, 0) - span;
    cz = $urandom_range(2 * span, 0) - span;
    sx = $urandom_range(2 * span, 0) - span;
    sy = $urandom_range(2 * span, 0) - span;
    sz = $urandom_range(2 * span, 0) - span;
    r  = $urandom_range(span, 0);
    shift = $urandom_range(3, 0);
    send(sx, sy, sz,
         ((cx - sx) <<< 1 >>> shift) + int'($urandom_range(span / 4, 0)) - span / 8,
         ((cy - sy) <<< 1 >>> shift) + int'($urandom_range(span / 4, 0)) - span / 8,
         ((cz - sz) <<< 1 >>> shift) + int'($urandom_range(span / 4, 0)) - span / 8,
         cx, cy, cz, r);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(-1, -1, -1, -1, -1, -1, -1, -1, -1, 32'h7fffffff);
    send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
         32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
         32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff);
    // start inside
    send(0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);
    // degenerate segment outside
    send(-3 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE);
    // start on the surface, moving in and moving out
    send(-ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);
    send(-ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, ONE);
    // moving away
    send(-3 * ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, ONE);
    // passes beside, no real root
    send(-3 * ONE, 2 * ONE, 0, 6 * ONE, 0, 0, 0, 0, 0, ONE);
    // tangent
    send(-3 * ONE, ONE, 0, 6 * ONE, 0, 0, 0, 0, 0, ONE);
    // ends before the sphere
    send(-5 * ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 0, ONE);
    // hits exactly at the end, and halfway
    send(-2 * ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);
    send(-2 * ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 0, ONE);
    // root just above zero, below one step of t
    send(-ONE - 1, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, ONE);
    // along the y and z axes with negative coordinates, then along the diagonal
    send(0, -9 * ONE, 0, 0, 12 * ONE, 0, 0, 0, 0, 2 * ONE);
    send(0, 0, 7 * ONE, 0, 0, -ONE * 5, 0, 0, 0, 3 * ONE);
    send(ONE, ONE, ONE, ONE * 4, ONE * 4, ONE * 4, ONE * 4, ONE * 4, ONE * 4, ONE);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) quiet_sender = ($urandom_range(3, 0) == 0);
      if (i == 400) hold_off_due = 1'b1;
      if ($urandom_range(4, 0) == 0)
        send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom);
      else
        send_aimed();
    end
    in_valid <= 1'b0;

    while (pending != 0 || u_checker.crossings_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d requests sent, %0d of them hit the sphere", requests_sent, hits_seen);
    $display("%0d mismatches", fails);
    if (fails == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        if ($urandom_range(150, 0) == 0) quiet_receiver = ~quiet_receiver;
        n = quiet_receiver ? 0 : $urandom_range(13, 0);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

endmodule

// ===== files.f =====
hw/rtl/ssi_pkg.sv
hw/rtl/ssi_wmul.sv
hw/rtl/segment_sphere_intersection.sv
verif/ssi_checker.sv
verif/testbench.sv
